>>> design/tdmd_pkg.sv
package tdmd_pkg;

   // Operation codes carried by a request transaction.
   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // Kind of a response transaction.
   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   // Packet status reported at the last byte of every packet.
   typedef enum logic [1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_COLLECTING = 2'd1,
      STATUS_RESET_DONE = 2'd2,
      STATUS_ERROR      = 2'd3
   } status_type;

   // Framing tokens, first character in the most significant byte.
   localparam int START_LEN = 7;
   localparam int RESET_LEN = 7;
   localparam int END_LEN   = 5;
   localparam logic [8*START_LEN-1:0] TOKEN_START = "<start>";
   localparam logic [8*RESET_LEN-1:0] TOKEN_RESET = "<reset>";
   localparam logic [8*END_LEN-1:0]   TOKEN_END   = "<end>";

   // Depth of the queue between front and back; a power of two.
   localparam int QUEUE_DEPTH = 2;

   // One classified request, as it travels from the front to the back.
   typedef struct packed {
      logic                 is_read;
      logic                 read_oob;
      logic [7:0]           data_byte;
      logic                 first;
      logic                 last;
      logic [15:0]          packet_length;
      logic [15:0]          read_address;
      logic [START_LEN-1:0] start_hit;
      logic [RESET_LEN-1:0] reset_hit;
      logic [END_LEN-1:0]   end_hit;
   } item_type;

endpackage

>>> design/token_delimited_message_deframer.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  operation, data_byte, first/last marks,
//                                           packet_length, read_address
// rsp_      out        rsp_valid/rsp_stall  result_kind, status, message_length, read_byte
//
// One transaction per cycle sustained while rsp_stall stays low; a result passes through
// the queue slot, then the message store's registered read port and the output register.
// Each item uses the store's single write or read port at most once.
// Reset is synchronous; the message store has no clearing pass and its bytes are
// undefined until written.
// Requests keep flowing into a two-entry queue while a result waits under rsp_stall.
module token_delimited_message_deframer
   import tdmd_pkg::*;
#(
   parameter int MESSAGE_CAPACITY = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_packet,
   input  logic        req_last_of_packet,
   input  logic [15:0] req_packet_length,
   input  logic [15:0] req_read_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [1:0]  rsp_status,
   output logic [16:0] rsp_message_length,
   output logic [7:0]  rsp_read_byte
);

   logic     q_full;
   logic     q_push;
   item_type q_push_item;
   logic     q_pop;
   logic     q_valid;
   item_type q_head_item;

   // Front: takes request transactions and classifies each byte.
   tdmd_front #(
      .MESSAGE_CAPACITY (MESSAGE_CAPACITY)
   ) u_front (
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_data_byte       (req_data_byte),
      .req_first_of_packet (req_first_of_packet),
      .req_last_of_packet  (req_last_of_packet),
      .req_packet_length   (req_packet_length),
      .req_read_address    (req_read_address),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_item              (q_push_item)
   );

   // Short queue decoupling the two halves.
   tdmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head_item (q_head_item)
   );

   // Back: message state, store and response register.
   tdmd_back #(
      .MESSAGE_CAPACITY (MESSAGE_CAPACITY)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_head_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_status         (rsp_status),
      .rsp_message_length (rsp_message_length),
      .rsp_read_byte      (rsp_read_byte)
   );

endmodule

>>> design/tdmd_ram.sv
module tdmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/tdmd_front.sv
module tdmd_front
   import tdmd_pkg::*;
#(
   parameter int MESSAGE_CAPACITY = 65536
) (
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_packet,
   input  logic        req_last_of_packet,
   input  logic [15:0] req_packet_length,
   input  logic [15:0] req_read_address,
   input  logic        q_full,
   output logic        q_push,
   output item_type    q_item
);

   // A transaction is taken whenever the queue has room.
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Classify the byte against every token character so the back only ANDs flags.
   always_comb begin
      q_item               = '0;
      q_item.is_read       = (req_operation == OP_READ);
      q_item.read_oob      = (32'(req_read_address) >= 32'(MESSAGE_CAPACITY));
      q_item.data_byte     = req_data_byte;
      q_item.first         = req_first_of_packet;
      q_item.last          = req_last_of_packet;
      q_item.packet_length = req_packet_length;
      q_item.read_address  = req_read_address;
      for (int j = 0; j < START_LEN; j++) begin
         q_item.start_hit[j] = (req_data_byte == TOKEN_START[8*(START_LEN-1-j) +: 8]);
      end
      for (int j = 0; j < RESET_LEN; j++) begin
         q_item.reset_hit[j] = (req_data_byte == TOKEN_RESET[8*(RESET_LEN-1-j) +: 8]);
      end
      for (int j = 0; j < END_LEN; j++) begin
         q_item.end_hit[j] = (req_data_byte == TOKEN_END[8*(END_LEN-1-j) +: 8]);
      end
   end

endmodule

>>> design/tdmd_queue.sv
module tdmd_queue
   import tdmd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type head_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   // Pointers wrap naturally since the depth is a power of two.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/tdmd_back.sv
module tdmd_back
   import tdmd_pkg::*;
#(
   parameter int MESSAGE_CAPACITY = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [1:0]  rsp_status,
   output logic [16:0] rsp_message_length,
   output logic [7:0]  rsp_read_byte
);

   localparam int LEN_W  = $clog2(MESSAGE_CAPACITY);
   localparam int ADDR_W = $clog2(MESSAGE_CAPACITY);
   localparam int SUM_W  = ((LEN_W > 16) ? LEN_W : 16) + 1;
   localparam logic [SUM_W-1:0] CAP_SUM = SUM_W'(MESSAGE_CAPACITY);

   // Message and packet state.
   logic              coll_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [15:0]       idx_ff;
   logic [15:0]       total_ff;
   logic              ovf_ff;
   logic              start_ok_ff;
   logic              reset_ok_ff;
   logic [END_LEN-1:0] tail_hit_ff [END_LEN];

   // Output register.
   logic              out_valid_ff;
   kind_type          out_kind_ff;
   status_type        out_status_ff;
   logic [16:0]       out_len_ff;
   logic              out_oob_ff;

   logic              coll_in;
   logic [LEN_W-1:0]  len_in;
   status_type        status_in;
   logic [16:0]       out_len_in;

   logic              pop;
   logic              pkt_start;
   logic [15:0]       idx;
   logic [15:0]       total;
   logic [SUM_W-1:0]  first_sum;
   logic              ovf;
   logic              in_head;
   logic              start_ok;
   logic              reset_ok;
   logic [END_LEN-1:0] tail_now [END_LEN+1];
   logic              e1_raw;
   logic              e2_raw;
   logic              e1;
   logic              e2;
   logic [16:0]       plen_c;
   logic [SUM_W-1:0]  base_coll;
   logic [SUM_W-1:0]  base_start;
   logic [SUM_W-1:0]  base_sel;
   logic [SUM_W-1:0]  cut;
   logic [SUM_W-1:0]  closed;
   logic [SUM_W-1:0]  len_wide;
   logic [SUM_W-1:0]  append_addr;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic              ram_re;
   logic [7:0]        ram_rdata;

   // The back advances whenever the output register is free or being emptied.
   assign pop   = q_valid && (!out_valid_ff || !rsp_stall);
   assign q_pop = pop;

   // Byte position, overflow and token tracking for the current packet byte.
   always_comb begin
      pkt_start = q_item.first || (idx_ff == '0);
      idx       = pkt_start ? 16'd0 : idx_ff;
      total     = pkt_start ? q_item.packet_length : total_ff;
      first_sum = SUM_W'(len_ff) + SUM_W'(q_item.packet_length);
      ovf       = (pkt_start ? (first_sum >= CAP_SUM) : ovf_ff) || (idx >= total);
      in_head   = (idx < 16'(START_LEN));
      start_ok  = in_head ? ((pkt_start || start_ok_ff) && q_item.start_hit[idx[2:0]])
                          : start_ok_ff;
      reset_ok  = in_head ? ((pkt_start || reset_ok_ff) && q_item.reset_hit[idx[2:0]])
                          : reset_ok_ff;
      for (int k = 0; k < END_LEN; k++) begin
         tail_now[k] = tail_hit_ff[k];
      end
      tail_now[END_LEN] = q_item.end_hit;
      e1_raw = 1'b1;
      e2_raw = 1'b1;
      for (int k = 0; k < END_LEN; k++) begin
         e1_raw = e1_raw && tail_now[k+1][k];
         e2_raw = e2_raw && tail_now[k][k];
      end
   end

   // Store write: appended while collecting, or after the start token otherwise.
   always_comb begin
      append_addr = SUM_W'(len_ff) + SUM_W'(idx);
      ram_waddr   = coll_ff ? append_addr[ADDR_W-1:0] : ADDR_W'(idx - 16'(START_LEN));
      ram_we      = pop && !q_item.is_read && !ovf
                    && (coll_ff || (!in_head && start_ok));
      ram_re      = pop && q_item.is_read;
   end

   // Packet outcome at the last byte.
   always_comb begin
      plen_c     = 17'(idx) + 17'd1;
      base_coll  = SUM_W'(len_ff) + SUM_W'(plen_c);
      base_start = SUM_W'(plen_c - 17'(START_LEN));
      base_sel   = coll_ff ? base_coll : base_start;
      e1         = (plen_c >= 17'(END_LEN)) && e1_raw;
      e2         = (plen_c >= 17'(END_LEN + 1)) && e2_raw;
      cut        = e1 ? SUM_W'(END_LEN) : SUM_W'(END_LEN + 1);
      closed     = (base_sel > cut) ? (base_sel - cut) : '0;
      coll_in    = coll_ff;
      len_in     = len_ff;
      status_in  = STATUS_ERROR;
      if (ovf) begin
         status_in = STATUS_ERROR;
      end else if (coll_ff && (plen_c < 17'(END_LEN))) begin
         len_in    = LEN_W'(base_coll);
         status_in = STATUS_COLLECTING;
      end else if ((plen_c >= 17'(RESET_LEN)) && reset_ok) begin
         coll_in   = 1'b0;
         len_in    = '0;
         status_in = STATUS_RESET_DONE;
      end else if (coll_ff || ((plen_c >= 17'(START_LEN)) && start_ok)) begin
         if (e1 || e2) begin
            coll_in   = 1'b0;
            len_in    = LEN_W'(closed);
            status_in = STATUS_DONE;
         end else begin
            coll_in   = 1'b1;
            len_in    = LEN_W'(base_sel);
            status_in = STATUS_COLLECTING;
         end
      end else begin
         coll_in   = 1'b0;
         len_in    = '0;
         status_in = STATUS_ERROR;
      end
      len_wide   = q_item.is_read ? SUM_W'(len_ff) : SUM_W'(len_in);
      out_len_in = len_wide[16:0];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         coll_ff      <= 1'b0;
         len_ff       <= '0;
         idx_ff       <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         start_ok_ff  <= 1'b0;
         reset_ok_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < END_LEN; k++) begin
            tail_hit_ff[k] <= '0;
         end
      end else begin
         if (pop) begin
            out_valid_ff <= q_item.is_read || q_item.last;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (pop && !q_item.is_read) begin
            total_ff    <= total;
            start_ok_ff <= start_ok;
            reset_ok_ff <= reset_ok;
            for (int k = 0; k < END_LEN; k++) begin
               tail_hit_ff[k] <= tail_now[k+1];
            end
            if (q_item.last) begin
               idx_ff  <= '0;
               ovf_ff  <= 1'b0;
               coll_ff <= coll_in;
               len_ff  <= len_in;
            end else begin
               idx_ff <= (idx == 16'hFFFF) ? idx : idx + 16'd1;
               ovf_ff <= ovf;
            end
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         out_kind_ff   <= q_item.is_read ? KIND_READ : KIND_STATUS;
         out_status_ff <= q_item.is_read ? STATUS_DONE : status_in;
         out_len_ff    <= out_len_in;
         out_oob_ff    <= q_item.read_oob;
      end
   end

   tdmd_ram #(
      .WIDTH (8),
      .DEPTH (MESSAGE_CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (q_item.data_byte),
      .rd_en   (ram_re),
      .rd_addr (ADDR_W'(q_item.read_address)),
      .rd_data (ram_rdata)
   );

   // Read data comes from the store's output register, zero for a status result or an out-of-range address.
   assign rsp_valid          = out_valid_ff;
   assign rsp_result_kind    = out_kind_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_message_length = out_len_ff;
   assign rsp_read_byte      = ((out_kind_ff == KIND_READ) && !out_oob_ff) ? ram_rdata : 8'd0;

   // A held result must not be overwritten, or the store read data would move under it.
   a_no_pop_while_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !q_pop)
      else $error("back advanced while a result was held");

   // The last byte of a packet always rewinds the byte position.
   a_index_rewound: assert property (@(posedge clock) disable iff (reset)
      pop && !q_item.is_read && q_item.last |=> idx_ff == '0)
      else $error("byte position not rewound after packet end");

   // A rejected packet leaves the message as it was.
   a_reject_keeps_state: assert property (@(posedge clock) disable iff (reset)
      pop && !q_item.is_read && q_item.last && ovf
      |=> len_ff == $past(len_ff) && coll_ff == $past(coll_ff))
      else $error("rejected packet changed the message");

   // The message never reaches capacity.
   a_length_in_range: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(len_ff) < CAP_SUM)
      else $error("message length reached capacity");

endmodule

>>> sim/tb_token_delimited_message_deframer.sv
`timescale 1ns / 100ps

module tb_token_delimited_message_deframer;
   import tdmd_pkg::*;

   localparam int MSG_CAPACITY   = 65536;
   localparam int TARGET_ITEMS   = 1850;
   localparam int QUIET_ITEMS    = 150;
   localparam int SETTLE_SPACING = 600;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   // One request transaction as queued for the driver.
   typedef struct {
      bit          settle_first;
      logic        op;
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [15:0] plen;
      logic [15:0] raddr;
   } deframe_req_type;

   // One response transaction as the deframer should produce it.
   typedef struct {
      kind_type    kind;
      status_type  status;
      logic [16:0] msg_length;
      logic [7:0]  rdata;
   } deframe_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_PACKET;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first_of_packet = 1'b0;
   logic        req_last_of_packet = 1'b0;
   logic [15:0] req_packet_length = 16'h0000;
   logic [15:0] req_read_address = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [1:0]  rsp_status;
   logic [16:0] rsp_message_length;
   logic [7:0]  rsp_read_byte;

   // Stimulus and the responses still owed by the deframer.
   deframe_req_type stimulus[$];
   deframe_rsp_type results_due[$];
   bit              settle_next = 1'b0;
   bit              quiet_tail = 1'b0;

   // Predicted deframer state.
   bit          msg_open = 1'b0;
   int unsigned msg_len = 0;
   logic [7:0]  msg_mem [0:MSG_CAPACITY-1];
   bit          msg_written [0:MSG_CAPACITY-1];
   int unsigned written_addrs[$];
   logic [8*START_LEN-1:0] head_win = '0;
   logic [47:0] tail_win = '0;
   int unsigned pkt_index = 0;
   int unsigned pkt_total = 0;
   bit          pkt_rejected = 1'b0;

   // Driver and monitor bookkeeping.
   deframe_req_type held_item;
   bit              item_held = 1'b0;
   int              send_gap = 0;
   int              recv_gap = 0;
   int              requests_sent = 0;
   int              results_predicted = 0;
   int              results_checked = 0;
   int              mismatch_count = 0;
   int              idle_cycles = 0;
   int              status_seen [0:3] = '{0, 0, 0, 0};
   int              reads_seen = 0;

   token_delimited_message_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_data_byte      (req_data_byte),
      .req_first_of_packet(req_first_of_packet),
      .req_last_of_packet (req_last_of_packet),
      .req_packet_length  (req_packet_length),
      .req_read_address   (req_read_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_status         (rsp_status),
      .rsp_message_length (rsp_message_length),
      .rsp_read_byte      (rsp_read_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply the end-token rule to a grown message length and return the status.
   function automatic status_type close_on_end(input int unsigned grown,
                                               input int unsigned plen);
      bit          end_last;
      bit          end_before_last;
      int unsigned trim;
      end_last        = plen >= END_LEN && tail_win[39:0] == TOKEN_END;
      end_before_last = plen >= END_LEN + 1 && tail_win[47:8] == TOKEN_END;
      if (end_last || end_before_last) begin
         trim     = end_last ? END_LEN : END_LEN + 1;
         msg_len  = (grown > trim) ? grown - trim : 0;
         msg_open = 1'b0;
         return STATUS_DONE;
      end
      msg_len  = grown;
      msg_open = 1'b1;
      return STATUS_COLLECTING;
   endfunction

   // Advance the predicted state by one accepted request and queue any response it owes.
   function automatic void deframe_step(input deframe_req_type it);
      deframe_rsp_type res;
      int unsigned     idx;
      int unsigned     plen;
      int unsigned     addr;
      bit              wr;
      status_type      st;
      if (it.op == OP_READ) begin
         res.kind       = KIND_READ;
         res.status     = STATUS_DONE;
         res.msg_length = 17'(msg_len);
         res.rdata      = (it.raddr < MSG_CAPACITY) ? msg_mem[it.raddr] : 8'h00;
         results_due.push_back(res);
         results_predicted++;
         return;
      end

      // A first mark, or any byte while no packet is open, begins a packet.
      if (it.first || pkt_index == 0) begin
         pkt_index    = 0;
         pkt_total    = it.plen;
         pkt_rejected = (msg_len + it.plen >= MSG_CAPACITY);
      end
      idx = pkt_index;
      if (idx >= pkt_total)
         pkt_rejected = 1'b1;
      if (idx < START_LEN)
         head_win[8*(START_LEN-idx)-1 -: 8] = it.data;
      tail_win = {tail_win[39:0], it.data};

      // Store the byte when appending, or past the start token of an opening packet.
      if (!pkt_rejected) begin
         wr   = 1'b0;
         addr = 0;
         if (msg_open) begin
            addr = msg_len + idx;
            wr   = 1'b1;
         end else if (idx >= START_LEN && head_win == TOKEN_START) begin
            addr = idx - START_LEN;
            wr   = 1'b1;
         end
         if (wr && addr < MSG_CAPACITY) begin
            msg_mem[addr] = it.data;
            if (!msg_written[addr]) begin
               msg_written[addr] = 1'b1;
               written_addrs.push_back(addr);
            end
         end
      end

      if (!it.last) begin
         if (pkt_index < 16'hFFFF)
            pkt_index++;
         return;
      end

      // Last byte: decide what the packet did to the message.
      plen = idx + 1;
      if (pkt_rejected) begin
         st = STATUS_ERROR;
      end else if (msg_open && plen < END_LEN) begin
         msg_len += plen;
         st = STATUS_COLLECTING;
      end else if (plen >= RESET_LEN && head_win == TOKEN_RESET) begin
         msg_open = 1'b0;
         msg_len  = 0;
         st       = STATUS_RESET_DONE;
      end else if (!msg_open && plen >= START_LEN && head_win == TOKEN_START) begin
         st = close_on_end(plen - START_LEN, plen);
      end else if (msg_open) begin
         st = close_on_end(msg_len + plen, plen);
      end else begin
         msg_open = 1'b0;
         msg_len  = 0;
         st       = STATUS_ERROR;
      end
      pkt_index    = 0;
      pkt_rejected = 1'b0;

      res.kind       = KIND_STATUS;
      res.status     = st;
      res.msg_length = 17'(msg_len);
      res.rdata      = 8'h00;
      results_due.push_back(res);
      results_predicted++;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic push_item(input logic op, input logic [7:0] data, input logic first,
                            input logic last, input logic [15:0] plen,
                            input logic [15:0] raddr);
      deframe_req_type it;
      it.settle_first = settle_next;
      it.op           = op;
      it.data         = data;
      it.first        = first;
      it.last         = last;
      it.plen         = plen;
      it.raddr        = raddr;
      settle_next     = 1'b0;
      stimulus.push_back(it);
   endtask

   // The address of a store read is chosen by the driver from bytes already written.
   task automatic push_read();
      push_item(OP_READ, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
                16'h0000);
   endtask

   task automatic add_text(ref logic [7:0] body[$], input string s);
      for (int i = 0; i < s.len(); i++)
         body.push_back(s[i]);
   endtask

   task automatic add_random(ref logic [7:0] body[$], input int n);
      repeat (n) body.push_back(8'($urandom));
   endtask

   task automatic add_closing(ref logic [7:0] body[$]);
      add_text(body, "<end>");
      if ($urandom_range(0, 2) == 0)
         body.push_back(8'($urandom));
   endtask

   // Mostly the true length; sometimes longer, shorter or close to the capacity.
   function automatic logic [15:0] pick_announce(input int n);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 86)
         return 16'(n);
      if (roll < 92)
         return (n + 300 > 65535) ? 16'hFFFF : 16'(n + $urandom_range(1, 300));
      if (roll < 96)
         return 16'($urandom_range(0, n - 1));
      return 16'($urandom_range(60000, 65535));
   endfunction

   task automatic send_packet(input logic [7:0] body[$], input logic [15:0] announced,
                              input bit mark_first, input bit with_last,
                              input bit sprinkle_reads);
      for (int i = 0; i < body.size(); i++) begin
         if (sprinkle_reads && i > 0 && $urandom_range(0, 19) == 0)
            push_read();
         push_item(OP_PACKET, body[i], mark_first && i == 0,
                   with_last && i == body.size() - 1,
                   (i == 0) ? announced : 16'($urandom), 16'($urandom));
      end
   endtask

   // Driver: one request transaction held at a time, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            deframe_step(held_item);
            requests_sent++;
            item_held = 1'b0;
            if (!quiet_tail && $urandom_range(0, 9) == 0)
               send_gap = $urandom_range(1, 19);
         end
         if (!item_held) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (stimulus.size() > 0 && !(stimulus[0].settle_first &&
                         results_checked != results_predicted)) begin
               held_item = stimulus.pop_front();
               if (held_item.op == OP_READ)
                  held_item.raddr =
                     16'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
               item_held = 1'b1;
            end
         end
         req_valid           <= item_held;
         req_operation       <= held_item.op;
         req_data_byte       <= held_item.data;
         req_first_of_packet <= held_item.first;
         req_last_of_packet  <= held_item.last;
         req_packet_length   <= held_item.plen;
         req_read_address    <= held_item.raddr;
      end
   end

   // Monitor: stall the response channel in bursts and check every response transaction.
   always @(posedge clock) begin
      deframe_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $display("%0t: response with none expected, expected nothing,", $time,
                        " actual kind %0h status %0h length %0h byte %0h",
                        rsp_result_kind, rsp_status, rsp_message_length, rsp_read_byte);
               mismatch_count++;
            end else begin
               want = results_due.pop_front();
               check_field("result_kind", want.kind, rsp_result_kind);
               check_field("status", want.status, rsp_status);
               check_field("message_length", want.msg_length, rsp_message_length);
               check_field("read_byte", want.rdata, rsp_read_byte);
               if (want.kind == KIND_READ)
                  reads_seen++;
               else
                  status_seen[want.status]++;
               results_checked <= results_checked + 1;
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            recv_gap = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: give up when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] body[$];
      int         next_settle;
      int         n;

      // Directed: open with extreme data bytes, then capacity, end plus trailing byte,
      // a stray idle byte without first mark, a packet cut short and a zero length.
      body = {};
      add_text(body, "<start>");
      body.push_back(8'hFF);
      body.push_back(8'h00);
      send_packet(body, 16'd9, 1'b1, 1'b1, 1'b0);
      push_read();
      push_item(OP_PACKET, "Q", 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
      body = {};
      add_text(body, "<end>x");
      send_packet(body, 16'd6, 1'b1, 1'b1, 1'b0);
      push_item(OP_PACKET, "<", 1'b0, 1'b1, 16'd1, 16'h0000);
      push_item(OP_PACKET, "a", 1'b1, 1'b0, 16'd2, 16'h0000);
      push_item(OP_PACKET, "b", 1'b0, 1'b0, 16'h0000, 16'hFFFF);
      push_item(OP_PACKET, "c", 1'b1, 1'b1, 16'h0000, 16'h0000);
      push_read();
      settle_next = 1'b1;

      // Random: mostly whole messages, the rest malformed or stray packets.
      next_settle = SETTLE_SPACING;
      while (stimulus.size() < TARGET_ITEMS) begin
         if (stimulus.size() >= next_settle) begin
            settle_next = 1'b1;
            next_settle += SETTLE_SPACING;
         end
         if ($urandom_range(0, 9) < 7) begin
            body = {};
            add_text(body, "<start>");
            add_random(body, $urandom_range(0, 12));
            if ($urandom_range(0, 4) == 0) begin
               add_closing(body);
               send_packet(body, pick_announce(body.size()), 1'b1, 1'b1, 1'b1);
            end else begin
               send_packet(body, pick_announce(body.size()), 1'b1, 1'b1, 1'b1);
               repeat ($urandom_range(0, 3)) begin
                  body = {};
                  if ($urandom_range(0, 9) == 0) begin
                     add_text(body, "<reset>");
                     add_random(body, $urandom_range(0, 2));
                  end else begin
                     add_random(body, $urandom_range(1, 14));
                  end
                  send_packet(body, pick_announce(body.size()), 1'b1, 1'b1, 1'b1);
               end
               body = {};
               add_random(body, $urandom_range(0, 10));
               add_closing(body);
               send_packet(body, pick_announce(body.size()), 1'b1, 1'b1, 1'b1);
            end
         end else begin
            body = {};
            case ($urandom_range(0, 4))
               0: begin
                  add_random(body, $urandom_range(1, 10));
                  send_packet(body, pick_announce(body.size()), 1'b1, 1'b1, 1'b1);
               end
               1: begin
                  add_text(body, ($urandom_range(0, 1) == 0) ? "<start>" : "<reset>");
                  n = $urandom_range(1, 6);
                  body = body[0:n-1];
                  send_packet(body, pick_announce(body.size()), 1'b1, 1'b1, 1'b1);
               end
               2: begin
                  add_random(body, $urandom_range(1, 5));
                  send_packet(body, pick_announce(body.size()), 1'b1, 1'b0, 1'b1);
               end
               3: begin
                  add_random(body, $urandom_range(1, 8));
                  send_packet(body, pick_announce(body.size()), 1'b0, 1'b1, 1'b1);
               end
               default: begin
                  add_random(body, $urandom_range(1, 3));
                  send_packet(body, 16'h0000, 1'b1, 1'b1, 1'b1);
               end
            endcase
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) push_read();
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The last stretch starts no new random gaps on either side.
      while (stimulus.size() > QUIET_ITEMS)
         @(negedge clock);
      quiet_tail = 1'b1;
      while (stimulus.size() != 0 || item_held)
         @(negedge clock);
      while (results_checked != results_predicted)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d request transactions and checked %0d responses.",
               requests_sent, results_checked);
      $display("Packets: %0d complete, %0d collecting, %0d reset, %0d error; %0d reads.",
               status_seen[STATUS_DONE], status_seen[STATUS_COLLECTING],
               status_seen[STATUS_RESET_DONE], status_seen[STATUS_ERROR], reads_seen);
      if (mismatch_count == 0 && results_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> token_delimited_message_deframer.f
design/tdmd_pkg.sv
design/tdmd_ram.sv
design/tdmd_front.sv
design/tdmd_queue.sv
design/tdmd_back.sv
design/token_delimited_message_deframer.sv
sim/tb_token_delimited_message_deframer.sv
